// ===== design/ssid_pkg.sv =====
`default_nettype none
package ssid_pkg;

    localparam int VALUE_W = 32;
    localparam int COUNT_W = 5;

    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_DELETE = 1'b1;

    typedef enum logic [1:0] {
        RD_IDX = 2'd0,
        RD_JM1 = 2'd1,
        RD_JP1 = 2'd2
    } t_rd_sel;

    typedef enum logic {
        WR_SHIFT = 1'b0,
        WR_ITEM  = 1'b1
    } t_wr_sel;

    typedef struct packed {
        logic    load;
        logic    idx_inc;
        logic    rd_en;
        t_rd_sel rd_sel;
        logic    j_load_fill;
        logic    j_load_idx;
        logic    j_dec;
        logic    j_inc;
        logic    wr_en;
        t_wr_sel wr_sel;
        logic    fill_inc;
        logic    fill_dec;
        logic    res_load;
        logic    res_ok;
        logic    res_full;
    } t_dp_cmd;

    typedef struct packed {
        logic cmd_del;
        logic scan_end;
        logic less;
        logic equal;
        logic full;
        logic ins_more;
        logic del_more;
        logic out_free;
    } t_dp_stat;

endpackage
`default_nettype wire

// ===== design/sorted_set_insert_delete.sv =====
// Sorted set of up to CAPACITY distinct signed 32-bit values, kept in ascending order in a
// single-port-read table. Each input item (i_cmd: 0 insert, 1 delete; i_value) yields exactly
// one result item: o_ok when the set changed, o_full_reject when an insert of an absent value
// found the table full, and o_entry_count, the count after the command (modulo 32). One item
// is worked at a time; o_stall is high from the cycle after acceptance until the result is
// loaded. The linear search reads the stored entries in ascending order until one is not below
// the value, and the shift that opens or closes a slot moves one entry at a time, each read
// going through the table's registered read port. If the previous result is still held in the
// output register by i_stall, the last step waits until it is taken.
// A finished result waits in the output register while the next item may be accepted.
// No clearing pass is needed after reset; only occupied slots are ever read.
`default_nettype none
module sorted_set_insert_delete #(
    parameter int CAPACITY = 16
) (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    // command side
    input  wire                                i_valid,
    output logic                               o_stall,
    input  wire                                i_cmd,
    input  wire signed [ssid_pkg::VALUE_W-1:0] i_value,
    // result side
    output logic                               o_valid,
    input  wire                                i_stall,
    output logic                               o_ok,
    output logic                               o_full_reject,
    output logic [ssid_pkg::COUNT_W-1:0]       o_entry_count
);

    ssid_pkg::t_dp_cmd  w_ctl;
    ssid_pkg::t_dp_stat w_stat;
    logic               w_busy;

    // sequencer: search, then shift up for insert or down for delete
    ssid_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_stat  (w_stat),
        .o_ctl   (w_ctl),
        .o_busy  (w_busy)
    );

    // table, index counters, fill count and result register
    ssid_dp #(
        .CAPACITY (CAPACITY)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (i_cmd),
        .i_value       (i_value),
        .i_stall       (i_stall),
        .i_ctl         (w_ctl),
        .o_stat        (w_stat),
        .o_valid       (o_valid),
        .o_ok          (o_ok),
        .o_full_reject (o_full_reject),
        .o_entry_count (o_entry_count)
    );

    // busy whenever an item is in the sequencer
    assign o_stall = w_busy;

    // a full refusal never comes with a change of the set
    a_full_not_ok : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_full_reject |-> !o_ok)
        else $error("full reject reported together with ok");

    // a full refusal only happens at capacity
    a_full_at_cap : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_full_reject |-> o_entry_count == ssid_pkg::COUNT_W'(CAPACITY))
        else $error("full reject below capacity");

    // an accepted item keeps the command side busy
    a_busy_after_accept : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall |=> o_stall)
        else $error("command side not busy after accept");

    // a result is loaded only when the sequencer returns to idle
    a_result_ends_item : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ctl.res_load |=> !o_stall && o_valid)
        else $error("result loaded without ending the item");

endmodule
`default_nettype wire

// ===== design/ssid_dp.sv =====
`default_nettype none
module ssid_dp #(
    parameter int CAPACITY = 16
) (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    input  wire                                i_cmd,
    input  wire signed [ssid_pkg::VALUE_W-1:0] i_value,
    input  wire                                i_stall,
    input  wire ssid_pkg::t_dp_cmd             i_ctl,
    output ssid_pkg::t_dp_stat                 o_stat,
    output logic                               o_valid,
    output logic                               o_ok,
    output logic                               o_full_reject,
    output logic [ssid_pkg::COUNT_W-1:0]       o_entry_count
);

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int AW = $clog2(CAPACITY);

    logic [ssid_pkg::VALUE_W-1:0] mem [CAPACITY];

    logic signed [ssid_pkg::VALUE_W-1:0] r_rdata;
    logic signed [ssid_pkg::VALUE_W-1:0] r_value;
    logic                                r_cmd;
    logic [CW-1:0]                       r_idx;
    logic [CW-1:0]                       r_j;
    logic [CW-1:0]                       r_fill;
    logic [CW-1:0]                       n_fill;
    logic                                r_out_valid;
    logic                                r_ok;
    logic                                r_full;
    logic [ssid_pkg::COUNT_W-1:0]        r_count;

    logic [CW-1:0]                       w_jm1;
    logic [CW:0]                         w_jp1;
    logic [AW-1:0]                       w_rd_addr;
    logic [AW-1:0]                       w_wr_addr;
    logic [ssid_pkg::VALUE_W-1:0]        w_wr_data;

    assign w_jm1 = r_j - 1'b1;
    assign w_jp1 = {1'b0, r_j} + 1'b1;

    always_comb begin
        unique case (i_ctl.rd_sel)
            ssid_pkg::RD_JM1: w_rd_addr = w_jm1[AW-1:0];
            ssid_pkg::RD_JP1: w_rd_addr = w_jp1[AW-1:0];
            default:          w_rd_addr = r_idx[AW-1:0];
        endcase
    end

    always_comb begin
        if (i_ctl.wr_sel == ssid_pkg::WR_SHIFT) begin
            w_wr_addr = r_j[AW-1:0];
            w_wr_data = r_rdata;
        end else begin
            w_wr_addr = r_idx[AW-1:0];
            w_wr_data = r_value;
        end
    end

    // table storage, one read and one write port
    always_ff @(posedge i_clk) begin
        if (i_ctl.wr_en) begin
            mem[w_wr_addr] <= w_wr_data;
        end
        if (i_ctl.rd_en) begin
            r_rdata <= mem[w_rd_addr];
        end
    end

    always_comb begin
        n_fill = r_fill;
        if (i_ctl.fill_inc) begin
            n_fill = r_fill + 1'b1;
        end else if (i_ctl.fill_dec) begin
            n_fill = r_fill - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_fill <= n_fill;
            if (i_ctl.res_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_value <= i_value;
            r_cmd   <= i_cmd;
        end
        if (i_ctl.load) begin
            r_idx <= '0;
        end else if (i_ctl.idx_inc) begin
            r_idx <= r_idx + 1'b1;
        end
        if (i_ctl.j_load_fill) begin
            r_j <= r_fill;
        end else if (i_ctl.j_load_idx) begin
            r_j <= r_idx;
        end else if (i_ctl.j_dec) begin
            r_j <= w_jm1;
        end else if (i_ctl.j_inc) begin
            r_j <= w_jp1[CW-1:0];
        end
        if (i_ctl.res_load) begin
            r_ok    <= i_ctl.res_ok;
            r_full  <= i_ctl.res_full;
            r_count <= ssid_pkg::COUNT_W'(n_fill);
        end
    end

    assign o_stat.cmd_del  = (r_cmd == ssid_pkg::CMD_DELETE);
    assign o_stat.scan_end = (r_idx == r_fill);
    assign o_stat.less     = (r_rdata < r_value);
    assign o_stat.equal    = (r_rdata == r_value);
    assign o_stat.full     = (r_fill == CW'(CAPACITY));
    assign o_stat.ins_more = (r_j > r_idx);
    assign o_stat.del_more = (w_jp1 < {1'b0, r_fill});
    assign o_stat.out_free = !r_out_valid || !i_stall;

    assign o_valid       = r_out_valid;
    assign o_ok          = r_ok;
    assign o_full_reject = r_full;
    assign o_entry_count = r_count;

endmodule
`default_nettype wire

// ===== design/ssid_ctrl.sv =====
`default_nettype none
module ssid_ctrl (
    input  wire                      i_clk,
    input  wire                      i_rst_n,
    input  wire                      i_valid,
    input  wire ssid_pkg::t_dp_stat  i_stat,
    output ssid_pkg::t_dp_cmd        o_ctl,
    output logic                     o_busy
);

    typedef enum logic [8:0] {
        S_IDLE     = 9'b0_0000_0001,
        S_SCAN     = 9'b0_0000_0010,
        S_SCAN_CHK = 9'b0_0000_0100,
        S_INS_CHK  = 9'b0_0000_1000,
        S_INS_WR   = 9'b0_0001_0000,
        S_DEL_CHK  = 9'b0_0010_0000,
        S_DEL_WR   = 9'b0_0100_0000,
        S_FAIL     = 9'b0_1000_0000,
        S_FULL     = 9'b1_0000_0000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        logic decide;
        logic found;
        decide  = 1'b0;
        found   = 1'b0;
        n_state = r_state;
        o_ctl   = '0;
        o_ctl.rd_sel = ssid_pkg::RD_IDX;
        o_ctl.wr_sel = ssid_pkg::WR_SHIFT;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_ctl.load = 1'b1;
                    n_state    = S_SCAN;
                end
            end
            S_SCAN: begin
                if (i_stat.scan_end) begin
                    decide = 1'b1;
                end else begin
                    o_ctl.rd_en = 1'b1;
                    n_state     = S_SCAN_CHK;
                end
            end
            S_SCAN_CHK: begin
                if (i_stat.less) begin
                    o_ctl.idx_inc = 1'b1;
                    n_state       = S_SCAN;
                end else begin
                    decide = 1'b1;
                    found  = i_stat.equal;
                end
            end
            S_INS_CHK: begin
                if (i_stat.ins_more) begin
                    o_ctl.rd_en  = 1'b1;
                    o_ctl.rd_sel = ssid_pkg::RD_JM1;
                    n_state      = S_INS_WR;
                end else if (i_stat.out_free) begin
                    o_ctl.wr_en    = 1'b1;
                    o_ctl.wr_sel   = ssid_pkg::WR_ITEM;
                    o_ctl.fill_inc = 1'b1;
                    o_ctl.res_load = 1'b1;
                    o_ctl.res_ok   = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            S_INS_WR: begin
                o_ctl.wr_en = 1'b1;
                o_ctl.j_dec = 1'b1;
                n_state     = S_INS_CHK;
            end
            S_DEL_CHK: begin
                if (i_stat.del_more) begin
                    o_ctl.rd_en  = 1'b1;
                    o_ctl.rd_sel = ssid_pkg::RD_JP1;
                    n_state      = S_DEL_WR;
                end else if (i_stat.out_free) begin
                    o_ctl.fill_dec = 1'b1;
                    o_ctl.res_load = 1'b1;
                    o_ctl.res_ok   = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            S_DEL_WR: begin
                o_ctl.wr_en = 1'b1;
                o_ctl.j_inc = 1'b1;
                n_state     = S_DEL_CHK;
            end
            S_FAIL: begin
                if (i_stat.out_free) begin
                    o_ctl.res_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            S_FULL: begin
                if (i_stat.out_free) begin
                    o_ctl.res_load = 1'b1;
                    o_ctl.res_full = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // search finished: pick the update path
        if (decide) begin
            if (!i_stat.cmd_del) begin
                if (found) begin
                    n_state = S_FAIL;
                end else if (i_stat.full) begin
                    n_state = S_FULL;
                end else begin
                    o_ctl.j_load_fill = 1'b1;
                    n_state           = S_INS_CHK;
                end
            end else begin
                if (found) begin
                    o_ctl.j_load_idx = 1'b1;
                    n_state          = S_DEL_CHK;
                end else begin
                    n_state = S_FAIL;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_busy = (r_state != S_IDLE);

endmodule
`default_nettype wire
